/* src/fol_pkg.sv */
// ----------------------------------------------------------------------------
// Frequency ordered list: shared package
// Types, constants and codes used by the list sequencer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fol_pkg;

  localparam int DEPTH     = 128;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int RANK_W    = 8;
  localparam int POS_W     = 7;
  localparam int ENTRIES_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [RANK_W-1:0]  RANK_MAX  = '1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ACCESS = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ_RD,
    ST_READ_GET,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_PUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                visited;
    logic [RANK_W-1:0]   rank;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic [ENTRIES_W-1:0] entries;
    logic [COUNT_W-1:0]   read_count;
    logic [VALUE_W-1:0]   read_value;
    logic [POS_W-1:0]     new_position;
    logic                 found;
  } result_t;

endpackage

`default_nettype wire

/* src/frequency_ordered_list.sv */
// ----------------------------------------------------------------------------
// Frequency ordered list
// Self-organizing list kept in order of access count, with first-visit rank
// as tie-break, held in one entry memory and worked by a small sequencer.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; s_axis_tready_o is low while it is at
// work. Every step of an access is one read through the single registered
// read port of the entry memory followed by a compare or a write-back. The
// result sits in an output register, so the next transaction is taken while
// it waits. No clearing pass is needed after reset.
`default_nettype none

module frequency_ordered_list (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] value, [38:32] position, [39] zero
  input  wire logic [39:0] s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] found, [7:1] new_position, [39:8] read_value, [55:40] read_count,
  // [63:56] entries
  output logic [63:0]      m_axis_tdata_o
);

  localparam int IDX_W = fol_pkg::IDX_W;
  localparam int CNT_W = fol_pkg::CNT_W;

  fol_pkg::state_e  state_q, state_d;
  logic [fol_pkg::VALUE_W-1:0] value_q, value_d;
  logic [fol_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [fol_pkg::RANK_W-1:0]  next_rank_q, next_rank_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  hit_q, hit_d;
  logic [IDX_W-1:0]  p_q, p_d;
  fol_pkg::entry_t   upd_q, upd_d;
  fol_pkg::result_t  res_q, res_d;
  fol_pkg::result_t  out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // entry memory, one write and one registered read per cycle
  fol_pkg::entry_t   mem_q [fol_pkg::DEPTH];
  fol_pkg::entry_t   rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  fol_pkg::entry_t   mem_wd;
  logic [IDX_W-1:0]  mem_ra;

  logic              in_fire;
  logic              out_free;
  logic              k_end;
  logic              k_is_hit;
  logic              k_at_p;
  logic              move_up;
  logic              match;
  logic              ahead;
  logic              len_full;
  logic              read_ok;
  logic              last_search;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign k_end       = (k_q == len_q);
  assign k_is_hit    = (k_q[IDX_W-1:0] == hit_q);
  assign k_at_p      = (k_q[IDX_W-1:0] == p_q);
  assign move_up     = (p_q > hit_q);
  assign match       = (rdata_q.value == value_q);
  assign len_full    = (len_q == CNT_W'(fol_pkg::DEPTH));
  assign read_ok     = (CNT_W'(pos_q) < len_q);
  assign last_search = ((k_q + CNT_W'(1)) == len_q);

  // the shared compare: does the scanned entry stay ahead of the moved one
  always_comb begin
    ahead = 1'b0;
    if (rdata_q.count > upd_q.count) begin
      ahead = 1'b1;
    end else if (rdata_q.count == upd_q.count) begin
      ahead = !rdata_q.visited || (upd_q.visited && (rdata_q.rank < upd_q.rank));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fol_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (fol_pkg::kind_e'(s_axis_tuser_i))
            fol_pkg::KIND_LOAD:   state_d = fol_pkg::ST_LOAD;
            fol_pkg::KIND_ACCESS: begin
              state_d = (len_q == '0) ? fol_pkg::ST_DONE : fol_pkg::ST_SRCH_RD;
            end
            fol_pkg::KIND_READ:   state_d = fol_pkg::ST_READ_RD;
            default:              state_d = fol_pkg::ST_DONE;
          endcase
        end
      end
      fol_pkg::ST_LOAD:     state_d = fol_pkg::ST_DONE;
      fol_pkg::ST_READ_RD:  state_d = read_ok ? fol_pkg::ST_READ_GET : fol_pkg::ST_DONE;
      fol_pkg::ST_READ_GET: state_d = fol_pkg::ST_DONE;
      fol_pkg::ST_SRCH_RD:  state_d = fol_pkg::ST_SRCH_CMP;
      fol_pkg::ST_SRCH_CMP: begin
        if (match) begin
          state_d = fol_pkg::ST_SCAN_RD;
        end else if (last_search) begin
          state_d = fol_pkg::ST_DONE;
        end else begin
          state_d = fol_pkg::ST_SRCH_RD;
        end
      end
      fol_pkg::ST_SCAN_RD: begin
        if (k_end) begin
          state_d = fol_pkg::ST_MOVE_RD;
        end else if (!k_is_hit) begin
          state_d = fol_pkg::ST_SCAN_CMP;
        end
      end
      fol_pkg::ST_SCAN_CMP: state_d = ahead ? fol_pkg::ST_SCAN_RD : fol_pkg::ST_MOVE_RD;
      fol_pkg::ST_MOVE_RD:  state_d = k_at_p ? fol_pkg::ST_PUT : fol_pkg::ST_MOVE_WR;
      fol_pkg::ST_MOVE_WR:  state_d = fol_pkg::ST_MOVE_RD;
      fol_pkg::ST_PUT:      state_d = fol_pkg::ST_DONE;
      fol_pkg::ST_DONE:     if (out_free) state_d = fol_pkg::ST_IDLE;
      default:              state_d = fol_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    value_d     = value_q;
    pos_d       = pos_q;
    len_d       = len_q;
    next_rank_d = next_rank_q;
    k_d         = k_q;
    hit_d       = hit_q;
    p_d         = p_q;
    upd_d       = upd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_wa      = k_q[IDX_W-1:0];
    mem_wd      = rdata_q;
    mem_ra      = k_q[IDX_W-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fol_pkg::ST_IDLE: begin
        if (in_fire) begin
          value_d = s_axis_tdata_i[31:0];
          pos_d   = s_axis_tdata_i[38:32];
          res_d   = '0;
          k_d     = '0;
          p_d     = '0;
        end
      end
      fol_pkg::ST_LOAD: begin
        if (!len_full) begin
          mem_we             = 1'b1;
          mem_wa             = len_q[IDX_W-1:0];
          mem_wd             = '0;
          mem_wd.value       = value_q;
          len_d              = len_q + CNT_W'(1);
          res_d.found        = 1'b1;
          res_d.new_position = fol_pkg::POS_W'(len_q);
        end
      end
      fol_pkg::ST_READ_RD: begin
        mem_ra = IDX_W'(pos_q);
      end
      fol_pkg::ST_READ_GET: begin
        res_d.found      = 1'b1;
        res_d.read_value = rdata_q.value;
        res_d.read_count = rdata_q.count;
      end
      fol_pkg::ST_SRCH_CMP: begin
        if (match) begin
          hit_d = k_q[IDX_W-1:0];
          upd_d = rdata_q;
          if (rdata_q.count != fol_pkg::COUNT_MAX) begin
            upd_d.count = rdata_q.count + fol_pkg::COUNT_W'(1);
          end
          if (!rdata_q.visited) begin
            upd_d.visited = 1'b1;
            upd_d.rank    = next_rank_q;
            if (next_rank_q != fol_pkg::RANK_MAX) begin
              next_rank_d = next_rank_q + fol_pkg::RANK_W'(1);
            end
          end
          k_d = '0;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      fol_pkg::ST_SCAN_RD: begin
        if (k_end) begin
          k_d = CNT_W'(hit_q);
        end else if (k_is_hit) begin
          k_d = k_q + CNT_W'(1);
        end
      end
      fol_pkg::ST_SCAN_CMP: begin
        if (ahead) begin
          p_d = p_q + IDX_W'(1);
          k_d = k_q + CNT_W'(1);
        end else begin
          k_d = CNT_W'(hit_q);
        end
      end
      fol_pkg::ST_MOVE_RD: begin
        // slide the neighbour towards the hole left by the moved entry
        mem_ra = move_up ? (k_q[IDX_W-1:0] + IDX_W'(1)) : (k_q[IDX_W-1:0] - IDX_W'(1));
      end
      fol_pkg::ST_MOVE_WR: begin
        mem_we = 1'b1;
        mem_wa = k_q[IDX_W-1:0];
        mem_wd = rdata_q;
        k_d    = move_up ? (k_q + CNT_W'(1)) : (k_q - CNT_W'(1));
      end
      fol_pkg::ST_PUT: begin
        mem_we             = 1'b1;
        mem_wa             = p_q;
        mem_wd             = upd_q;
        res_d.found        = 1'b1;
        res_d.new_position = fol_pkg::POS_W'(p_q);
      end
      fol_pkg::ST_DONE: begin
        if (out_free) begin
          out_d         = res_q;
          out_d.entries = fol_pkg::ENTRIES_W'(len_q);
          out_valid_d   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fol_pkg::ST_IDLE;
      len_q       <= '0;
      next_rank_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      next_rank_q <= next_rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
    k_q     <= k_d;
    hit_q   <= hit_d;
    p_q     <= p_d;
    upd_q   <= upd_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign s_axis_tready_o = (state_q == fol_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

/* src/fol_chk.sv */
// ----------------------------------------------------------------------------
// Frequency ordered list: port checker
// Concurrent checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fol_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o
);

  logic [7:0] entries;
  logic [6:0] new_pos;

  assign entries = m_axis_tdata_o[63:56];
  assign new_pos = m_axis_tdata_o[7:1];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  a_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> entries <= 8'(fol_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> {1'b0, new_pos} < entries)
    else $error("position outside the list");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[55:1] == '0)
    else $error("miss carries data");

endmodule

bind frequency_ordered_list fol_chk u_fol_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
